// File: src/fpss_pkg.sv
// ----------------------------------------------------------------------------
// fpss_pkg
// Shared types and constants of the fractional-N PLL setting solver.
// ----------------------------------------------------------------------------
package fpss_pkg;

    localparam int RATE_W    = 32;
    localparam int QUOT_W    = 8;
    localparam int MULT_W    = 7;
    localparam int FRAC_W    = 22;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [RATE_W-1:0] FOUT_MIN_RST = 32'd620000000;
    localparam logic [RATE_W-1:0] FOUT_MAX_RST = 32'd700000000;

    localparam logic [CFG_IDX_W-1:0] REG_FOUT_MIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOUT_MAX = 8'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_WINDOW = 3'd1,
        ST_ZERO   = 3'd2,
        ST_MULT   = 3'd3,
        ST_FRAC   = 3'd4
    } t_status;

    // Per-item control that rides alongside the partial remainders.
    typedef struct packed {
        t_status             status;
        logic [RATE_W-1:0]   ref_rate;
    } t_tag;

endpackage

// File: src/fpss_int_div.sv
// ----------------------------------------------------------------------------
// fpss_int_div
// Restoring divider for the integer quotient, one quotient bit per stage,
// most significant bit first. The dividend must be below ref_rate << QUOT_W.
// ----------------------------------------------------------------------------
module fpss_int_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  fpss_pkg::t_tag                i_tag,
    input  logic [fpss_pkg::RATE_W-1:0]   i_rem,
    output logic                          o_valid,
    input  logic                          i_ready,
    output fpss_pkg::t_tag                o_tag,
    output logic [fpss_pkg::RATE_W-1:0]   o_rem,
    output logic [fpss_pkg::QUOT_W-1:0]   o_quot
);
    import fpss_pkg::*;

    localparam int S  = QUOT_W;
    localparam int CW = RATE_W + QUOT_W;

    logic              s_valid [0:S];
    logic              s_ready [0:S];
    t_tag              s_tag   [0:S];
    logic [RATE_W-1:0] s_rem   [0:S];
    logic [QUOT_W-1:0] s_quot  [0:S];

    logic              r_valid [S];
    t_tag              r_tag   [S];
    logic [RATE_W-1:0] r_rem   [S];
    logic [QUOT_W-1:0] r_quot  [S];

    assign s_valid[0] = i_valid;
    assign s_tag[0]   = i_tag;
    assign s_rem[0]   = i_rem;
    assign s_quot[0]  = '0;
    assign s_ready[S] = i_ready;
    assign o_ready    = s_ready[0];

    for (genvar k = 0; k < S; k++) begin : g_stage
        localparam int SH = S - 1 - k;

        logic [CW-1:0]     w_trial;
        logic [CW-1:0]     w_div;
        logic [CW-1:0]     w_diff;
        logic              w_ge;
        logic [RATE_W-1:0] n_rem;
        logic [QUOT_W-1:0] n_quot;

        always_comb begin
            w_trial = {{QUOT_W{1'b0}}, s_rem[k]};
            w_div   = {{QUOT_W{1'b0}}, s_tag[k].ref_rate} << SH;
            w_diff  = w_trial - w_div;
            w_ge    = (w_trial >= w_div);
            n_rem   = w_ge ? w_diff[RATE_W-1:0] : s_rem[k];
            n_quot  = s_quot[k];
            n_quot[SH] = w_ge;
        end

        // A stage takes new data when it is empty or its content moves on.
        assign s_ready[k] = !s_valid[k+1] || s_ready[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (s_ready[k]) begin
                r_valid[k] <= s_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_ready[k] && s_valid[k]) begin
                r_tag[k]  <= s_tag[k];
                r_rem[k]  <= n_rem;
                r_quot[k] <= n_quot;
            end
        end

        assign s_valid[k+1] = r_valid[k];
        assign s_tag[k+1]   = r_tag[k];
        assign s_rem[k+1]   = r_rem[k];
        assign s_quot[k+1]  = r_quot[k];
    end

    assign o_valid = s_valid[S];
    assign o_tag   = s_tag[S];
    assign o_rem   = s_rem[S];
    assign o_quot  = s_quot[S];

endmodule

// File: src/fpss_frac_div.sv
// ----------------------------------------------------------------------------
// fpss_frac_div
// Long division of (rem << FRAC_BITS) by ref_rate, one fraction bit per
// stage. The remainder enters below ref_rate; the leftover remainder is
// passed on for the rounding step.
// ----------------------------------------------------------------------------
module fpss_frac_div #(
    parameter int FRAC_BITS = 22
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  fpss_pkg::t_tag                i_tag,
    input  logic [fpss_pkg::RATE_W-1:0]   i_rem,
    input  logic [fpss_pkg::QUOT_W-1:0]   i_quot,
    output logic                          o_valid,
    input  logic                          i_ready,
    output fpss_pkg::t_tag                o_tag,
    output logic [fpss_pkg::RATE_W-1:0]   o_rem,
    output logic [fpss_pkg::QUOT_W-1:0]   o_quot,
    output logic [FRAC_BITS-1:0]          o_frac
);
    import fpss_pkg::*;

    localparam int S = FRAC_BITS;

    logic              s_valid [0:S];
    logic              s_ready [0:S];
    t_tag              s_tag   [0:S];
    logic [RATE_W-1:0] s_rem   [0:S];
    logic [QUOT_W-1:0] s_quot  [0:S];
    logic [S-1:0]      s_frac  [0:S];

    logic              r_valid [S];
    t_tag              r_tag   [S];
    logic [RATE_W-1:0] r_rem   [S];
    logic [QUOT_W-1:0] r_quot  [S];
    logic [S-1:0]      r_frac  [S];

    assign s_valid[0] = i_valid;
    assign s_tag[0]   = i_tag;
    assign s_rem[0]   = i_rem;
    assign s_quot[0]  = i_quot;
    assign s_frac[0]  = '0;
    assign s_ready[S] = i_ready;
    assign o_ready    = s_ready[0];

    for (genvar k = 0; k < S; k++) begin : g_stage
        localparam int BIT = S - 1 - k;

        logic [RATE_W:0]   w_dbl;
        logic [RATE_W:0]   w_div;
        logic [RATE_W:0]   w_diff;
        logic              w_ge;
        logic [RATE_W-1:0] n_rem;
        logic [S-1:0]      n_frac;

        always_comb begin
            w_dbl  = {s_rem[k], 1'b0};
            w_div  = {1'b0, s_tag[k].ref_rate};
            w_diff = w_dbl - w_div;
            w_ge   = (w_dbl >= w_div);
            // Either way the new remainder is below ref_rate and fits the word.
            n_rem  = w_ge ? w_diff[RATE_W-1:0] : w_dbl[RATE_W-1:0];
            n_frac = s_frac[k];
            n_frac[BIT] = w_ge;
        end

        assign s_ready[k] = !s_valid[k+1] || s_ready[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (s_ready[k]) begin
                r_valid[k] <= s_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_ready[k] && s_valid[k]) begin
                r_tag[k]  <= s_tag[k];
                r_rem[k]  <= n_rem;
                r_quot[k] <= s_quot[k];
                r_frac[k] <= n_frac;
            end
        end

        assign s_valid[k+1] = r_valid[k];
        assign s_tag[k+1]   = r_tag[k];
        assign s_rem[k+1]   = r_rem[k];
        assign s_quot[k+1]  = r_quot[k];
        assign s_frac[k+1]  = r_frac[k];
    end

    assign o_valid = s_valid[S];
    assign o_tag   = s_tag[S];
    assign o_rem   = s_rem[S];
    assign o_quot  = s_quot[S];
    assign o_frac  = s_frac[S];

endmodule

// File: src/fractional_pll_setting_solver_unit.sv
// Throughput: one rate pair per cycle while the result side keeps accepting; each divider
// stage retires one quotient bit, so the depth is set by the eight integer-quotient stages
// and the FRAC_BITS fraction stages. Reset (synchronous, active low) empties every stage
// and restores the output window to 620 MHz .. 700 MHz.
// ----------------------------------------------------------------------------
// fractional_pll_setting_solver_unit
// Computes the integer multiplier and the rounded fractional word of a
// fractional-N PLL from a target rate and a reference rate, with range checks.
// ----------------------------------------------------------------------------
module fractional_pll_setting_solver_unit #(
    parameter int ND_MAX    = 127,
    parameter int FRAC_BITS = 22
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fpss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fpss_pkg::RATE_W-1:0]      i_cfg_data,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] target_rate, [63:32] reference_rate
    input  logic [63:0]                      s_axis_tdata,
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [6:0] multiplier, [28:7] fraction, [31:29] zero
    output logic [31:0]                      m_axis_tdata,
    // [2:0] status
    output logic [fpss_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import fpss_pkg::*;

    // Configuration registers.
    logic [RATE_W-1:0] r_fout_min;
    logic [RATE_W-1:0] r_fout_max;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fout_min <= FOUT_MIN_RST;
            r_fout_max <= FOUT_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FOUT_MIN: r_fout_min <= i_cfg_data;
                REG_FOUT_MAX: r_fout_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Entry stage: window, zero and quotient-size checks.
    logic [RATE_W-1:0] w_target;
    logic [RATE_W-1:0] w_ref;
    t_status           n_e_status;

    assign w_target = s_axis_tdata[RATE_W-1:0];
    assign w_ref    = s_axis_tdata[2*RATE_W-1:RATE_W];

    always_comb begin
        if (w_target < r_fout_min || w_target > r_fout_max) begin
            n_e_status = ST_WINDOW;
        end else if (w_target == '0 || w_ref == '0) begin
            n_e_status = ST_ZERO;
        end else if ({{QUOT_W{1'b0}}, w_target} >= {w_ref, {QUOT_W{1'b0}}}) begin
            // The quotient reaches 2^QUOT_W, which is at least ND_MAX.
            n_e_status = ST_MULT;
        end else begin
            n_e_status = ST_OK;
        end
    end

    logic              r_e_valid;
    t_tag              r_e_tag;
    logic [RATE_W-1:0] r_e_rem;
    logic              w_e_ready;
    logic              w_id_ready;

    assign w_e_ready     = !r_e_valid || w_id_ready;
    assign s_axis_tready = w_e_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_e_ready) begin
            r_e_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_ready && s_axis_tvalid) begin
            r_e_tag.status   <= n_e_status;
            r_e_tag.ref_rate <= w_ref;
            r_e_rem          <= w_target;
        end
    end

    // Integer quotient.
    logic              w_id_valid;
    t_tag              w_id_tag;
    logic [RATE_W-1:0] w_id_rem;
    logic [QUOT_W-1:0] w_id_quot;
    logic              w_fd_ready;

    fpss_int_div u_int_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_valid),
        .o_ready (w_id_ready),
        .i_tag   (r_e_tag),
        .i_rem   (r_e_rem),
        .o_valid (w_id_valid),
        .i_ready (w_fd_ready),
        .o_tag   (w_id_tag),
        .o_rem   (w_id_rem),
        .o_quot  (w_id_quot)
    );

    // Fraction bits.
    logic                 w_fd_valid;
    t_tag                 w_fd_tag;
    logic [RATE_W-1:0]    w_fd_rem;
    logic [QUOT_W-1:0]    w_fd_quot;
    logic [FRAC_BITS-1:0] w_fd_frac;
    logic                 w_out_ready;

    fpss_frac_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_id_valid),
        .o_ready (w_fd_ready),
        .i_tag   (w_id_tag),
        .i_rem   (w_id_rem),
        .i_quot  (w_id_quot),
        .o_valid (w_fd_valid),
        .i_ready (w_out_ready),
        .o_tag   (w_fd_tag),
        .o_rem   (w_fd_rem),
        .o_quot  (w_fd_quot),
        .o_frac  (w_fd_frac)
    );

    // Output stage: rounding, multiplier range and fraction overflow.
    // Adding half the divisor before the divide equals adding one to the
    // truncated fraction when the leftover remainder plus that half reaches it.
    logic [RATE_W:0]           w_round_sum;
    logic                      w_round_up;
    logic                      w_frac_ovf;
    logic                      w_mult_bad;
    logic [FRAC_BITS-1:0]      w_frac_rnd;
    logic [QUOT_W-1:0]         w_mult_full;
    logic [FRAC_W+FRAC_BITS-1:0] w_frac_ext;
    t_status                   n_out_status;
    logic [MULT_W-1:0]         n_out_mult;
    logic [FRAC_W-1:0]         n_out_frac;

    always_comb begin
        w_round_sum = {1'b0, w_fd_rem} + {2'b0, w_fd_tag.ref_rate[RATE_W-1:1]};
        w_round_up  = (w_round_sum >= {1'b0, w_fd_tag.ref_rate});
        w_frac_ovf  = (&w_fd_frac) && w_round_up;
        w_frac_rnd  = w_fd_frac + {{(FRAC_BITS-1){1'b0}}, w_round_up};
        w_mult_bad  = (w_fd_quot == '0) || (w_fd_quot >= QUOT_W'(ND_MAX));
        w_mult_full = w_fd_quot - {{(QUOT_W-1){1'b0}}, 1'b1};
        w_frac_ext  = {{FRAC_W{1'b0}}, w_frac_rnd};

        n_out_mult = '0;
        n_out_frac = '0;
        if (w_fd_tag.status != ST_OK) begin
            n_out_status = w_fd_tag.status;
        end else if (w_mult_bad) begin
            n_out_status = ST_MULT;
        end else if (w_frac_ovf) begin
            n_out_status = ST_FRAC;
        end else begin
            n_out_status = ST_OK;
            n_out_mult   = w_mult_full[MULT_W-1:0];
            n_out_frac   = w_frac_ext[FRAC_W-1:0];
        end
    end

    logic              r_out_valid;
    t_status           r_out_status;
    logic [MULT_W-1:0] r_out_mult;
    logic [FRAC_W-1:0] r_out_frac;

    assign w_out_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_fd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_fd_valid) begin
            r_out_status <= n_out_status;
            r_out_mult   <= n_out_mult;
            r_out_frac   <= n_out_frac;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {{(32-MULT_W-FRAC_W){1'b0}}, r_out_frac, r_out_mult};

`ifndef SYNTHESIS
    // A failed check never leaks a partial multiplier or fraction.
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("nonzero payload on an error result");

    // Only defined status codes reach the output.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_FRAC))
        else $error("undefined status code on the output");

    // A write to the lower window bound lands in the register.
    a_cfg_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == REG_FOUT_MIN)
        |=> (r_fout_min == $past(i_cfg_data)))
        else $error("fout_min write lost");
`endif

endmodule

// File: tb/sv/fractional_pll_setting_solver_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_pll_setting_solver_unit_test
// Streams rate pairs into the solver under several output windows. Each
// transfer is predicted in the testbench and the result is checked field by
// field. Both stream sides stall at random, with one long hold-off on the
// result side.
// ----------------------------------------------------------------------------
module fractional_pll_setting_solver_unit_test;

    import fpss_pkg::*;

    localparam int ND_LIMIT     = 127;
    localparam int FRAC_SHIFT   = 22;
    localparam int DRAIN_CYCLES = FRAC_SHIFT + 18;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int BLOCKS       = 8;
    localparam int BLOCK_ITEMS  = 250;
    localparam logic [31:0] RATE_TOP = 32'hFFFF_FFFF;
    // No register sits at this index, so writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'hFF;

    typedef struct packed {
        t_status             status;
        logic [MULT_W-1:0]   mult;
        logic [FRAC_W-1:0]   frac;
    } t_setting;

    class pll_setting_check;
        logic [RATE_W-1:0] win_lo;
        logic [RATE_W-1:0] win_hi;
        t_setting          pending_settings[$];
        int                errors;
        int                pairs_seen;

        function new();
            win_lo     = FOUT_MIN_RST;
            win_hi     = FOUT_MAX_RST;
            errors     = 0;
            pairs_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
            if (idx == REG_FOUT_MIN) begin
                win_lo = data;
            end else if (idx == REG_FOUT_MAX) begin
                win_hi = data;
            end
        endfunction

        function t_setting solve_setting(logic [31:0] target, logic [31:0] refclk);
            logic [63:0] wide_ref;
            logic [63:0] quot;
            logic [63:0] rem;
            logic [63:0] frac;
            t_setting    s;
            s.status = ST_OK;
            s.mult   = '0;
            s.frac   = '0;
            wide_ref = {32'd0, refclk};
            if (target < win_lo || target > win_hi) begin
                s.status = ST_WINDOW;
            end else if (target == 0 || refclk == 0) begin
                s.status = ST_ZERO;
            end else begin
                quot = {32'd0, target} / wide_ref;
                rem  = {32'd0, target} % wide_ref;
                if (quot == 0 || quot >= ND_LIMIT) begin
                    s.status = ST_MULT;
                end else begin
                    // Round to nearest by adding half the divisor first.
                    frac = ((rem << FRAC_SHIFT) + (wide_ref >> 1)) / wide_ref;
                    if (frac > (64'd1 << FRAC_SHIFT) - 1) begin
                        s.status = ST_FRAC;
                    end else begin
                        s.mult = quot[MULT_W-1:0] - 1'b1;
                        s.frac = frac[FRAC_W-1:0];
                    end
                end
            end
            return s;
        endfunction

        function void note_pair(logic [31:0] target, logic [31:0] refclk);
            pending_settings.push_back(solve_setting(target, refclk));
            pairs_seen++;
        endfunction

        function void check_result(logic [31:0] tdata, logic [STATUS_W-1:0] tuser);
            t_setting want;
            if (pending_settings.size() == 0) begin
                $display("%0t: result with nothing pending: tdata=%h tuser=%h",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            want = pending_settings.pop_front();
            if (tuser !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, tuser);
                errors++;
            end
            if (tdata[6:0] !== want.mult) begin
                $display("%0t: multiplier expected %0d actual %0d",
                         $time, want.mult, tdata[6:0]);
                errors++;
            end
            if (tdata[28:7] !== want.frac) begin
                $display("%0t: fraction expected %h actual %h", $time, want.frac, tdata[28:7]);
                errors++;
            end
            if (tdata[31:29] !== 3'd0) begin
                $display("%0t: pad bits expected 0 actual %b", $time, tdata[31:29]);
                errors++;
            end
        endfunction

        function int pending();
            return pending_settings.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [RATE_W-1:0]     i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    pll_setting_check settings = new();
    int  cycle_count = 0;
    int  gap_odds    = 3;
    bit  calm        = 0;
    bit  held        = 0;

    fractional_pll_setting_solver_unit #(
        .ND_MAX    (ND_LIMIT),
        .FRAC_BITS (FRAC_SHIFT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fractional_pll_setting_solver_unit_test: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            settings.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Result side: random ready pattern, one long hold-off once 300 pairs have been sent.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                m_axis_tready = 1'b1;
            end else if (!held && settings.pairs_seen >= 300) begin
                held          = 1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    function automatic int pick_gap();
        if (calm || gap_odds == 0 || $urandom_range(0, gap_odds) != 0) begin
            return 0;
        end
        return $urandom_range(1, 12);
    endfunction

    task automatic send_pair(logic [31:0] target, logic [31:0] refclk);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {refclk, target};
        do @(posedge i_clk); while (!s_axis_tready);
        settings.note_pair(target, refclk);
    endtask

    // Stops the stream and waits until every pending result has been checked.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (settings.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        settings.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_window(logic [31:0] lo, logic [31:0] hi);
        cfg_write(REG_FOUT_MIN, lo);
        cfg_write(REG_FOUT_MAX, hi);
    endtask

    // Mostly solvable pairs with random content, the rest noise and edge values.
    task automatic random_pair(output logic [31:0] target, output logic [31:0] refclk);
        logic [63:0] prod;
        logic [31:0] lo;
        logic [31:0] hi;
        int          kind;
        int          q;
        lo   = settings.win_lo;
        hi   = settings.win_hi;
        kind = $urandom_range(0, 9);
        if (kind < 7 && lo == 0 && hi == RATE_TOP && kind < 4) begin
            // Build the target from a chosen quotient and remainder.
            q      = $urandom_range(1, 126);
            refclk = $urandom >> $urandom_range(0, 31);
            if (refclk == 0) refclk = 1;
            prod = 64'(q) * 64'(refclk);
            if (prod > RATE_TOP) begin
                refclk = RATE_TOP / q;
                prod   = 64'(q) * 64'(refclk);
            end
            if ($urandom_range(0, 7) == 0) begin
                target = refclk - 1;
            end else begin
                target = $urandom % refclk;
            end
            if (prod + target > RATE_TOP) begin
                target = RATE_TOP - prod[31:0];
            end
            target = prod[31:0] + target;
        end else if (kind < 7) begin
            target = (lo <= hi) ? $urandom_range(hi, lo) : $urandom;
            q      = $urandom_range(1, 130);
            refclk = target / q;
            if ($urandom_range(0, 3) == 0) refclk = refclk + $urandom_range(0, 3);
        end else if (kind == 7) begin
            target = $urandom;
            refclk = $urandom;
        end else if (kind == 8) begin
            target = $urandom_range(0, 1) ? 32'd0 : $urandom;
            refclk = (target == 0) ? $urandom : 32'd0;
        end else begin
            case ($urandom_range(0, 3))
                0: target = lo - 1;
                1: target = lo;
                2: target = hi;
                default: target = hi + 1;
            endcase
            refclk = $urandom >> $urandom_range(0, 31);
        end
    endtask

    initial begin
        logic [31:0] target;
        logic [31:0] refclk;
        logic [31:0] lo;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Window after reset: both edges, zero reference, quotient limits, rounding.
        send_pair(32'd619999999, 32'd25000000);
        send_pair(32'd620000000, 32'd25000000);
        send_pair(32'd700000000, 32'd25000000);
        send_pair(32'd700000001, 32'd25000000);
        send_pair(32'd650000000, 32'd0);
        send_pair(32'd650000000, 32'd700000000);
        send_pair(32'd650000000, RATE_TOP);
        send_pair(32'd650000000, 32'd5000000);
        send_pair(32'd640000000, 32'd5079365);
        send_pair(32'd640000000, 32'd5039370);
        send_pair(32'd647999999, 32'd12000000);
        drain();

        // Fully open window: zero target and the widest rates.
        set_window(32'd0, RATE_TOP);
        send_pair(32'd0, 32'd1);
        send_pair(32'd0, 32'd0);
        send_pair(RATE_TOP, RATE_TOP);
        send_pair(RATE_TOP, 32'd1);
        send_pair(32'd126, 32'd1);
        send_pair(RATE_TOP, 32'h8000_0000);
        drain();

        // Inverted window rejects everything; an unmapped index changes nothing.
        set_window(32'd700000000, 32'd620000000);
        cfg_write(REG_NONE, 32'd0);
        send_pair(32'd650000000, 32'd25000000);
        send_pair(32'd0, 32'd1);
        drain();
        set_window(32'd650000000, 32'd650000000);
        send_pair(32'd650000000, 32'd25000000);
        send_pair(32'd650000001, 32'd25000000);
        drain();

        for (int blk = 0; blk < BLOCKS; blk++) begin
            if (blk == BLOCKS - 1) begin
                calm = 1;
                set_window(32'd0, RATE_TOP);
            end else begin
                gap_odds = $urandom_range(0, 4);
                case (blk % 4)
                    0: set_window(32'd0, RATE_TOP);
                    1: set_window(FOUT_MIN_RST, FOUT_MAX_RST);
                    2: begin
                        lo = $urandom_range(900000000, 400000000);
                        set_window(lo, lo + $urandom_range(0, 300000000));
                    end
                    default: begin
                        set_window($urandom, $urandom);
                        cfg_write(REG_NONE, $urandom);
                    end
                endcase
            end
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                random_pair(target, refclk);
                send_pair(target, refclk);
            end
            drain();
        end

        if (settings.errors == 0 && settings.pending() == 0) begin
            $display("fractional_pll_setting_solver_unit_test: clean");
        end else begin
            $display("fractional_pll_setting_solver_unit_test: errors");
        end
        $finish;
    end

endmodule
